// ===== rtl/cbl_pkg.sv =====
// ============================================================================
// cbl_pkg
// Shared types, constants and helpers of the clipped coverage blit core.
// ============================================================================
package cbl_pkg;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_RECT_X      = 3'd0;
    localparam logic [2:0] REG_RECT_Y      = 3'd1;
    localparam logic [2:0] REG_RECT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_RECT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_FORE_COLOR  = 3'd4;
    localparam logic [2:0] REG_ROTATION    = 3'd5;

    // Panel commands
    localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
    localparam logic [7:0] CMD_PAGE_SET     = 8'h2B;
    localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

    // Job queue between front and back
    localparam int JOB_FIFO_DEPTH = 4;

    typedef struct packed {
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic [10:0]        rect_width;
        logic [10:0]        rect_height;
        logic [23:0]        fore_color;
        logic [1:0]         rotation;
    } t_cfg;

    typedef struct packed {
        logic [7:0] coverage;
        logic       send_window;
        logic       visible;
        logic       blit_end;
    } t_job;

    // floor(p / 255) for any p up to 255 * 255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

// ===== rtl/cbl_in_if.sv =====
// ============================================================================
// cbl_in_if
// Coverage input channel: one coverage byte per transaction.
// ============================================================================
interface cbl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] coverage;

    modport source (output valid, output coverage, input ready);
    modport sink   (input valid, input coverage, output ready);
endinterface

// ===== rtl/cbl_out_if.sv =====
// ============================================================================
// cbl_out_if
// Panel bus output channel: one bus byte with its flags per transaction.
// ============================================================================
interface cbl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] bus_byte;
    logic       is_command;
    logic       blit_end;
    logic       last;

    modport source (output valid, output bus_byte, output is_command,
                    output blit_end, output last, input ready);
    modport sink   (input valid, input bus_byte, input is_command,
                    input blit_end, input last, output ready);
endinterface

// ===== rtl/cbl_front.sv =====
// ============================================================================
// cbl_front
// Accept coverage items, track the source position, clip and queue jobs.
// ============================================================================
module cbl_front #(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cbl_in_if.sink        i_in,
    input  cbl_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output cbl_pkg::t_job o_job
);

    logic [10:0]        r_col, n_col;
    logic [10:0]        r_row, n_row;
    logic               r_win_sent, n_win_sent;

    logic [10:0]        scr_w, scr_h;
    logic signed [17:0] rx, ry, sx, sy, px, py, scr_w_s, scr_h_s;
    logic               empty, area, vis, send_win, accept;
    logic               col_wrap, row_wrap, x_end, y_end;

    always_comb begin
        scr_w   = i_cfg.rotation[0] ? 11'(PANEL_HEIGHT) : 11'(PANEL_WIDTH);
        scr_h   = i_cfg.rotation[0] ? 11'(PANEL_WIDTH)  : 11'(PANEL_HEIGHT);
        scr_w_s = $signed({7'd0, scr_w});
        scr_h_s = $signed({7'd0, scr_h});
        rx      = $signed({{2{i_cfg.rect_x[15]}}, i_cfg.rect_x});
        ry      = $signed({{2{i_cfg.rect_y[15]}}, i_cfg.rect_y});
        sx      = rx + $signed({7'd0, i_cfg.rect_width});
        sy      = ry + $signed({7'd0, i_cfg.rect_height});
        px      = rx + $signed({7'd0, r_col});
        py      = ry + $signed({7'd0, r_row});

        empty = (i_cfg.rect_width == 11'd0) || (i_cfg.rect_height == 11'd0);
        area  = !sx[17] && (sx != 18'sd0) && (rx < scr_w_s) &&
                !sy[17] && (sy != 18'sd0) && (ry < scr_h_s);
        vis   = area && (r_col < i_cfg.rect_width) && (r_row < i_cfg.rect_height) &&
                !px[17] && (px < scr_w_s) && !py[17] && (py < scr_h_s);

        col_wrap = ({1'b0, r_col} + 12'd1) >= {1'b0, i_cfg.rect_width};
        row_wrap = ({1'b0, r_row} + 12'd1) >= {1'b0, i_cfg.rect_height};
        // last visible column: either the rectangle edge or the screen edge
        x_end    = ({1'b0, r_col} + 12'd1 == {1'b0, i_cfg.rect_width}) ||
                   (px == scr_w_s - 18'sd1);
        y_end    = ({1'b0, r_row} + 12'd1 == {1'b0, i_cfg.rect_height}) ||
                   (py == scr_h_s - 18'sd1);
        send_win = area && !r_win_sent;

        accept = i_in.valid && !i_full;

        o_push               = accept && !empty && (send_win || vis);
        o_job.coverage       = i_in.coverage;
        o_job.send_window    = send_win;
        o_job.visible        = vis;
        o_job.blit_end       = vis && x_end && y_end;

        n_col      = r_col;
        n_row      = r_row;
        n_win_sent = r_win_sent;
        if (accept && !empty) begin
            if (send_win) begin
                n_win_sent = 1'b1;
            end
            if (col_wrap) begin
                n_col = 11'd0;
                if (row_wrap) begin
                    n_row      = 11'd0;
                    n_win_sent = 1'b0;
                end else begin
                    n_row = r_row + 11'd1;
                end
            end else begin
                n_col = r_col + 11'd1;
            end
        end
    end

    assign i_in.ready = !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= 11'd0;
            r_row      <= 11'd0;
            r_win_sent <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_win_sent <= n_win_sent;
        end
    end

    // a job that shows nothing only exists to carry the window
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.send_window || o_job.visible))
        else $error("front queued an empty job");

    a_end_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.blit_end) |-> o_job.visible)
        else $error("blit end on a clipped pixel");

endmodule

// ===== rtl/cbl_job_fifo.sv =====
// ============================================================================
// cbl_job_fifo
// Short job queue that decouples the front from the byte sequencer.
// ============================================================================
module cbl_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cbl_pkg::t_job i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output cbl_pkg::t_job o_data
);

    localparam int DEPTH = cbl_pkg::JOB_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cbl_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full job queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty job queue");

endmodule

// ===== rtl/cbl_back.sv =====
// ============================================================================
// cbl_back
// Byte sequencer: window command and address bytes, then three scaled color bytes for a visible pixel.
// ============================================================================
module cbl_back #(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cbl_pkg::t_cfg i_cfg,
    input  logic          i_head_valid,
    input  cbl_pkg::t_job i_head,
    output logic          o_pop,
    cbl_out_if.source     o_out
);

    localparam logic [3:0] STEP_COL_CMD = 4'd0;
    localparam logic [3:0] STEP_X0_HI   = 4'd1;
    localparam logic [3:0] STEP_X0_LO   = 4'd2;
    localparam logic [3:0] STEP_X1_HI   = 4'd3;
    localparam logic [3:0] STEP_X1_LO   = 4'd4;
    localparam logic [3:0] STEP_PAGE_CMD = 4'd5;
    localparam logic [3:0] STEP_Y0_HI   = 4'd6;
    localparam logic [3:0] STEP_Y0_LO   = 4'd7;
    localparam logic [3:0] STEP_Y1_HI   = 4'd8;
    localparam logic [3:0] STEP_Y1_LO   = 4'd9;
    localparam logic [3:0] STEP_WR_CMD  = 4'd10;
    localparam logic [3:0] STEP_RED     = 4'd11;
    localparam logic [3:0] STEP_GREEN   = 4'd12;
    localparam logic [3:0] STEP_BLUE    = 4'd13;

    logic               r_busy;
    logic [3:0]         r_step;
    cbl_pkg::t_job      r_job;

    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_cmd;
    logic               r_out_end;
    logic               r_out_last;

    logic [10:0]        scr_w, scr_h;
    logic signed [17:0] sx, sy, scr_w_s, scr_h_s;
    logic [15:0]        x0, x1m, y0, y1m;
    logic [7:0]         chan, byte_val;
    logic [15:0]        prod;
    logic               cmd_val;
    logic [3:0]         end_step;
    logic               advance, finish;

    // clipped window corners
    always_comb begin
        scr_w   = i_cfg.rotation[0] ? 11'(PANEL_HEIGHT) : 11'(PANEL_WIDTH);
        scr_h   = i_cfg.rotation[0] ? 11'(PANEL_WIDTH)  : 11'(PANEL_HEIGHT);
        scr_w_s = $signed({7'd0, scr_w});
        scr_h_s = $signed({7'd0, scr_h});
        sx      = $signed({{2{i_cfg.rect_x[15]}}, i_cfg.rect_x}) +
                  $signed({7'd0, i_cfg.rect_width});
        sy      = $signed({{2{i_cfg.rect_y[15]}}, i_cfg.rect_y}) +
                  $signed({7'd0, i_cfg.rect_height});
        x0      = i_cfg.rect_x[15] ? 16'd0 : i_cfg.rect_x;
        y0      = i_cfg.rect_y[15] ? 16'd0 : i_cfg.rect_y;
        x1m     = (sx > scr_w_s) ? {5'd0, scr_w - 11'd1} : 16'(sx - 18'sd1);
        y1m     = (sy > scr_h_s) ? {5'd0, scr_h - 11'd1} : 16'(sy - 18'sd1);
    end

    // byte for the current step
    always_comb begin
        unique case (r_step)
            STEP_RED:   chan = i_cfg.fore_color[23:16];
            STEP_GREEN: chan = i_cfg.fore_color[15:8];
            default:    chan = i_cfg.fore_color[7:0];
        endcase
        prod    = chan * r_job.coverage;
        cmd_val = 1'b0;
        unique case (r_step)
            STEP_COL_CMD:  begin byte_val = cbl_pkg::CMD_COLUMN_SET; cmd_val = 1'b1; end
            STEP_X0_HI:    byte_val = x0[15:8];
            STEP_X0_LO:    byte_val = x0[7:0];
            STEP_X1_HI:    byte_val = x1m[15:8];
            STEP_X1_LO:    byte_val = x1m[7:0];
            STEP_PAGE_CMD: begin byte_val = cbl_pkg::CMD_PAGE_SET; cmd_val = 1'b1; end
            STEP_Y0_HI:    byte_val = y0[15:8];
            STEP_Y0_LO:    byte_val = y0[7:0];
            STEP_Y1_HI:    byte_val = y1m[15:8];
            STEP_Y1_LO:    byte_val = y1m[7:0];
            STEP_WR_CMD:   begin byte_val = cbl_pkg::CMD_MEMORY_WRITE; cmd_val = 1'b1; end
            default:       byte_val = cbl_pkg::div255(prod);
        endcase
    end

    assign end_step = r_job.visible ? STEP_BLUE : STEP_WR_CMD;
    assign advance  = r_busy && (!r_out_valid || o_out.ready);
    assign finish   = advance && (r_step == end_step);
    assign o_pop    = i_head_valid && (!r_busy || finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_COL_CMD;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_step <= i_head.send_window ? STEP_COL_CMD : STEP_RED;
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (advance) begin
            r_step <= r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= byte_val;
            r_out_cmd  <= cmd_val;
            r_out_end  <= (r_step == STEP_BLUE) && r_job.blit_end;
            r_out_last <= (r_step == end_step);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.bus_byte   = r_out_byte;
    assign o_out.is_command = r_out_cmd;
    assign o_out.blit_end   = r_out_end;
    assign o_out.last       = r_out_last;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= STEP_BLUE))
        else $error("sequencer step out of range");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_end) |-> (r_out_last && !r_out_cmd))
        else $error("blit end not on last pixel data byte");

endmodule

// ===== rtl/clipped_coverage_blit_core.sv =====
// ============================================================================
// clipped_coverage_blit_core
// Clipped coverage blit over black onto a panel byte bus.
// ============================================================================
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  --------------------------------------
//  i_in      in   valid/ready             coverage[7:0]
//  o_out     out  valid/ready             bus_byte[7:0], is_command, blit_end,
//                                         last
//  APB       in   psel/penable/pwrite     paddr[4:0], pwdata[31:0], prdata[31:0]
//
//  Bytes: a visible pixel takes 3 bus bytes, and the first item of a blit
//  adds 11 for the address window; the single byte sequencer in the back end
//  sets the pace of a pixel stream, and takes the next job as it sends the last byte.
//  Clipped items that carry no window are taken without queueing a job.
//  Reset: synchronous, active low; clears the configuration registers, counters and the queue.
//  Stalls: a 4-entry job queue lets the front keep taking items while the
//  output is held; the front stalls only when the queue is full.
//
module clipped_coverage_blit_core #(
    parameter int PANEL_WIDTH  = 320,
    parameter int PANEL_HEIGHT = 480
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cbl_in_if.sink                           i_in,
    cbl_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cbl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [cbl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cbl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    cbl_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          cfg_wr;

    logic          push, pop, full, head_valid;
    cbl_pkg::t_job push_job, head_job;

    // Register file: word address selects the register, writes in access phase
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                cbl_pkg::REG_RECT_X:      r_cfg.rect_x      <= pwdata[15:0];
                cbl_pkg::REG_RECT_Y:      r_cfg.rect_y      <= pwdata[15:0];
                cbl_pkg::REG_RECT_WIDTH:  r_cfg.rect_width  <= pwdata[10:0];
                cbl_pkg::REG_RECT_HEIGHT: r_cfg.rect_height <= pwdata[10:0];
                cbl_pkg::REG_FORE_COLOR:  r_cfg.fore_color  <= pwdata[23:0];
                cbl_pkg::REG_ROTATION:    r_cfg.rotation    <= pwdata[1:0];
                default:                  r_cfg             <= r_cfg;
            endcase
        end
    end

    // Read back: zero-extend each register
    always_comb begin
        unique case (reg_idx)
            cbl_pkg::REG_RECT_X:      prdata = {16'd0, r_cfg.rect_x};
            cbl_pkg::REG_RECT_Y:      prdata = {16'd0, r_cfg.rect_y};
            cbl_pkg::REG_RECT_WIDTH:  prdata = {21'd0, r_cfg.rect_width};
            cbl_pkg::REG_RECT_HEIGHT: prdata = {21'd0, r_cfg.rect_height};
            cbl_pkg::REG_FORE_COLOR:  prdata = {8'd0, r_cfg.fore_color};
            cbl_pkg::REG_ROTATION:    prdata = {30'd0, r_cfg.rotation};
            default:                  prdata = '0;
        endcase
    end

    // Front: take coverage items, advance the source position, classify
    cbl_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Queue: hold classified jobs while the bus side is busy or stalled
    cbl_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_data  (head_job)
    );

    // Back: emit window and pixel bytes through the output register
    cbl_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_out        (o_out)
    );

    // Config changes only while idle is up to the user: nothing may be queued across a write
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |-> !head_valid)
        else $error("configuration written with jobs pending");

    a_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (i_in.valid && i_in.ready))
        else $error("job queued without an input transaction");

endmodule
